@@ hw/rtl/bba_pkg.sv @@
// Package for the buddy block allocator: constants, payload structs and sequencer states.
`default_nettype none
package bba_pkg;
    localparam int HEAP_ORDER = 16;
    localparam int MIN_ORDER  = 2;
    localparam int IDX_W      = HEAP_ORDER - MIN_ORDER;
    localparam int LINK_W     = IDX_W + 1;
    localparam int NBLK       = 1 << IDX_W;
    localparam int NLEVELS    = HEAP_ORDER - MIN_ORDER + 1;
    localparam int LVL_W      = $clog2(NLEVELS + 1);
    localparam int ORD_W      = 6;
    localparam int STEP_W     = IDX_W + 1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } t_req;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORDER,
        S_SCAN,
        S_POPRD,
        S_POPWAIT,
        S_SPLIT,
        S_FCHECK,
        S_WALK,
        S_WALKWAIT,
        S_UNLINKRD,
        S_UNLINKWAIT,
        S_PUSH,
        S_RESP
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/bba_link_ram.sv @@
// Single-port link memory of the free lists, one link per minimum block, registered read.
`default_nettype none
module bba_link_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [bba_pkg::IDX_W-1:0] i_addr,
    input  wire logic [bba_pkg::LINK_W-1:0] i_wdata,
    output logic      [bba_pkg::LINK_W-1:0] o_rdata
);
    logic [bba_pkg::LINK_W-1:0] r_mem [bba_pkg::NBLK];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: request sequencer, list heads and link memory.
`default_nettype none
// A request is a transfer taken when start is high and busy is low; exactly one result
// follows, on o_rsp for a single cycle marked by o_done, and the receiver cannot stall it.
// The strobe comes in the first cycle in which busy is low again.
// The size's order is found one bit per cycle. Every list step then uses the single port
// of the link memory, with a wait state after each read. An allocate then scans the
// levels upward, pops the head of the first list that is not empty with a read and a
// wait state, pushes the upper half of each split onto its list, and ends in a response
// state. A free is first checked; for each level it then walks the list, a read and a
// wait state per node passed, and unlinks the buddy in a read and a wait state or ends
// a walk that misses it. A walk gives up after 2^14 nodes. Push and response states follow.
// i_heap_base_we writes the base.
module buddy_block_allocator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_heap_base_we,
    input  wire logic [31:0]     i_heap_base,
    input  wire logic            start,
    output logic                 busy,
    input  wire bba_pkg::t_req   i_req,
    output logic                 o_done,
    output bba_pkg::t_rsp        o_rsp
);
    localparam int IW = bba_pkg::IDX_W;
    localparam int LW = bba_pkg::LINK_W;
    localparam int VW = bba_pkg::LVL_W;
    localparam int OW = bba_pkg::ORD_W;
    localparam int SW = bba_pkg::STEP_W;

    bba_pkg::t_state r_state, n_state;
    logic [31:0] r_base;
    logic [LW-1:0] r_heads [bba_pkg::NLEVELS];
    logic [LW-1:0] n_head_val;
    logic [VW-1:0] n_head_idx;
    logic          n_head_we;

    logic          r_act;
    logic [31:0]   r_size, n_size;
    logic [31:0]   r_off, n_off;
    logic [OW-1:0] r_ord, n_ord;
    logic [OW-1:0] r_lvl, n_lvl;
    logic [IW-1:0] r_blk, n_blk;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_steps, n_steps;
    logic [$bits(bba_pkg::t_rsp)-1:0] r_rsp_bits;
    bba_pkg::t_rsp r_rsp, n_rsp;
    logic          r_done, n_done;

    logic          m_we;
    logic [IW-1:0] m_addr;
    logic [LW-1:0] m_wdata, m_rdata;

    bba_link_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    logic [VW-1:0] lv_idx;
    logic [LW-1:0] head_lv;
    logic [IW-1:0] buddy;
    logic [IW-1:0] bit_lv;
    logic [31:0]   ord_mask;

    always_comb begin
        lv_idx  = VW'(r_lvl - OW'(bba_pkg::MIN_ORDER));
        head_lv = r_heads[lv_idx];
        bit_lv  = IW'(1) << lv_idx;
        buddy   = r_blk ^ bit_lv;
        ord_mask = (32'd1 << r_ord) - 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
            r_base  <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < bba_pkg::NLEVELS; i++) begin
                r_heads[i] <= (i == bba_pkg::NLEVELS - 1) ? LW'(0) : LW'(bba_pkg::NBLK);
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_heap_base_we) begin
                r_base <= i_heap_base;
            end
            if (n_head_we) begin
                r_heads[n_head_idx] <= n_head_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bba_pkg::S_IDLE && start) begin
            r_act <= i_req.action;
        end
        r_size  <= n_size;
        r_off   <= n_off;
        r_ord   <= n_ord;
        r_lvl   <= n_lvl;
        r_blk   <= n_blk;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_rsp   <= n_rsp;
    end

    assign r_rsp_bits = r_rsp;

    always_comb begin
        n_state = r_state;
        n_size = r_size; n_off = r_off; n_ord = r_ord; n_lvl = r_lvl; n_blk = r_blk;
        n_cur = r_cur; n_prev = r_prev; n_steps = r_steps; n_rsp = r_rsp;
        n_done = 1'b0;
        n_head_we = 1'b0; n_head_idx = lv_idx; n_head_val = '0;
        m_we = 1'b0; m_addr = r_blk; m_wdata = '0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (start) begin
                    n_size = i_req.request_size - 32'd1;
                    n_off  = i_req.block_address - r_base;
                    n_ord  = '0;
                    n_rsp  = '0;
                    n_state = bba_pkg::S_ORDER;
                end
            end
            bba_pkg::S_ORDER: begin
                // One bit of the rounded order per cycle.
                if (r_size != 32'd0) begin
                    n_size = r_size >> 1;
                    n_ord  = r_ord + OW'(1);
                end else begin
                    if (r_ord < OW'(bba_pkg::MIN_ORDER)) n_ord = OW'(bba_pkg::MIN_ORDER);
                    n_lvl = (r_ord < OW'(bba_pkg::MIN_ORDER)) ? OW'(bba_pkg::MIN_ORDER) : r_ord;
                    n_state = (r_act == bba_pkg::ACT_ALLOC) ? bba_pkg::S_SCAN
                                                            : bba_pkg::S_FCHECK;
                end
            end
            bba_pkg::S_SCAN: begin
                if (r_lvl > OW'(bba_pkg::HEAP_ORDER)) begin
                    n_rsp.status = bba_pkg::ST_NO_SPACE;
                    n_state = bba_pkg::S_RESP;
                end else if (head_lv[IW]) begin
                    n_lvl = r_lvl + OW'(1);
                end else begin
                    n_blk = head_lv[IW-1:0];
                    n_state = bba_pkg::S_POPRD;
                end
            end
            bba_pkg::S_POPRD: begin
                m_addr = r_blk;
                n_state = bba_pkg::S_POPWAIT;
            end
            bba_pkg::S_POPWAIT: begin
                n_head_we = 1'b1;
                n_head_val = m_rdata;
                n_state = bba_pkg::S_SPLIT;
            end
            bba_pkg::S_SPLIT: begin
                // Push the upper half of each split onto its list, one level per cycle.
                if (r_lvl > r_ord) begin
                    n_lvl = r_lvl - OW'(1);
                    n_head_idx = VW'(r_lvl - OW'(1) - OW'(bba_pkg::MIN_ORDER));
                    m_addr = r_blk + (IW'(1) << n_head_idx);
                    m_we = 1'b1;
                    m_wdata = r_heads[n_head_idx];
                    n_head_we = 1'b1;
                    n_head_val = {1'b0, m_addr};
                end else begin
                    n_rsp.granted_address = r_base + {{(32-IW-bba_pkg::MIN_ORDER){1'b0}},
                                            r_blk, {bba_pkg::MIN_ORDER{1'b0}}};
                    n_state = bba_pkg::S_RESP;
                end
            end
            bba_pkg::S_FCHECK: begin
                if (r_ord > OW'(bba_pkg::HEAP_ORDER) ||
                    r_off >= (32'd1 << bba_pkg::HEAP_ORDER) ||
                    (r_off & ord_mask) != 32'd0) begin
                    n_rsp.status = bba_pkg::ST_BAD_FREE;
                    n_state = bba_pkg::S_RESP;
                end else begin
                    n_blk = r_off[bba_pkg::MIN_ORDER +: IW];
                    n_lvl = r_ord;
                    n_prev = LW'(bba_pkg::NBLK);
                    n_cur = r_heads[VW'(r_ord - OW'(bba_pkg::MIN_ORDER))];
                    n_steps = '0;
                    n_state = (r_ord == OW'(bba_pkg::HEAP_ORDER)) ? bba_pkg::S_PUSH
                                                                  : bba_pkg::S_WALK;
                end
            end
            bba_pkg::S_WALK: begin
                if (r_steps == SW'(bba_pkg::NBLK) || r_cur[IW]) begin
                    n_state = bba_pkg::S_PUSH;
                end else if (r_cur[IW-1:0] == buddy) begin
                    m_addr = r_cur[IW-1:0];
                    n_state = bba_pkg::S_UNLINKRD;
                end else begin
                    m_addr = r_cur[IW-1:0];
                    n_prev = r_cur;
                    n_steps = r_steps + SW'(1);
                    n_state = bba_pkg::S_WALKWAIT;
                end
            end
            bba_pkg::S_WALKWAIT: begin
                n_cur = m_rdata;
                n_state = bba_pkg::S_WALK;
            end
            bba_pkg::S_UNLINKRD: begin
                m_addr = r_cur[IW-1:0];
                n_state = bba_pkg::S_UNLINKWAIT;
            end
            bba_pkg::S_UNLINKWAIT: begin
                if (r_prev[IW]) begin
                    n_head_we = 1'b1;
                    n_head_val = m_rdata;
                end else begin
                    m_we = 1'b1;
                    m_addr = r_prev[IW-1:0];
                    m_wdata = m_rdata;
                end
                n_blk = r_blk & ~bit_lv;
                n_lvl = r_lvl + OW'(1);
                n_prev = LW'(bba_pkg::NBLK);
                n_steps = '0;
                if (r_lvl + OW'(1) == OW'(bba_pkg::HEAP_ORDER)) begin
                    n_state = bba_pkg::S_PUSH;
                end else begin
                    n_cur = r_heads[VW'(r_lvl + OW'(1) - OW'(bba_pkg::MIN_ORDER))];
                    n_state = bba_pkg::S_WALK;
                end
            end
            bba_pkg::S_PUSH: begin
                m_we = 1'b1;
                m_addr = r_blk;
                m_wdata = head_lv;
                n_head_we = 1'b1;
                n_head_val = {1'b0, r_blk};
                n_state = bba_pkg::S_RESP;
            end
            bba_pkg::S_RESP: begin
                n_done = 1'b1;
                n_state = bba_pkg::S_IDLE;
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
        // The whole heap is the only free block after reset, so its link is written as empty.
        if (!i_rst_n) begin
            m_we = 1'b1;
            m_addr = '0;
            m_wdata = LW'(bba_pkg::NBLK);
        end
    end

    assign busy   = (r_state != bba_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp_bits;

    // A result is strobed only in the cycle after the response state.
    a_done_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == bba_pkg::S_RESP))
        else $error("result strobe without response state");
    // Failed or bad requests report no address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != bba_pkg::ST_DONE) |-> o_rsp.granted_address == 32'd0)
        else $error("address on a failed request");
    // The block is busy while a result is being produced.
    a_busy_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_RESP) |-> busy)
        else $error("idle during response");
endmodule
`default_nettype wire
